@@ src/civil_datetime_to_epoch_seconds_defines.svh @@
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_seconds assertion macros
// Shared property wrappers for the date to epoch converter checks.
// ----------------------------------------------------------------------------
`ifndef CIVIL_DATETIME_TO_EPOCH_SECONDS_DEFINES_SVH
`define CIVIL_DATETIME_TO_EPOCH_SECONDS_DEFINES_SVH

// same-cycle implication, held off during reset
`define CDES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdes check failed");

// next-cycle implication, held off during reset
`define CDES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdes check failed");

`endif

@@ src/cdes_pkg.sv @@
// ----------------------------------------------------------------------------
// cdes_pkg
// Types, constants and tables for the civil date to epoch seconds converter.
// ----------------------------------------------------------------------------
package cdes_pkg;

    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 48;
    localparam int EPOCH_W     = 41;

    // register stages from input word to output word
    localparam int PIPE_DEPTH  = 7;

    // month - 1 + 12 * 2^28 keeps the dividend non-negative
    localparam logic signed [33:0] MONTH_OFS  = 34'sd3221225471;
    localparam logic signed [33:0] CARRY_BIAS = 34'sd268435456;
    // ceil(2^33 / 3): exact floor divide by 3 for 31-bit values
    localparam logic [62:0] RECIP3 = 63'd2863311531;
    // ceil(2^24 / 100): exact floor divide by 100 for 17-bit values
    localparam logic [34:0] RECIP100 = 35'd167773;

    localparam logic signed [33:0] YEAR_LOW  = -34'sd32767;
    localparam logic signed [33:0] YEAR_HIGH = 34'sd32767;
    // year bias, a multiple of 400 so the leap terms stay exact
    localparam logic signed [33:0] YEAR_BIAS = 34'sd33200;
    // 365*B + B/4 - B/100 + B/400 + 719468 for B = YEAR_BIAS
    localparam logic signed [26:0] DAY_BIAS  = 27'sd12845519;

    localparam logic signed [51:0] SECS_PER_DAY = 52'sd86400;
    localparam logic signed [51:0] T_BEGIN = -52'sd12687428 * SECS_PER_DAY;
    localparam logic signed [51:0] T_END   = 52'sd11248738 * SECS_PER_DAY;

    typedef struct packed {
        logic              bad_year;
        logic signed [24:0] days;
    } day_count_t;

    // day of a March-based year at which month (rem + 1) starts
    function automatic logic [8:0] march_doy(input logic [3:0] rem);
        logic [8:0] doy;
        case (rem)
            4'd0:    doy = 9'd306;
            4'd1:    doy = 9'd337;
            4'd2:    doy = 9'd0;
            4'd3:    doy = 9'd31;
            4'd4:    doy = 9'd61;
            4'd5:    doy = 9'd92;
            4'd6:    doy = 9'd122;
            4'd7:    doy = 9'd153;
            4'd8:    doy = 9'd184;
            4'd9:    doy = 9'd214;
            4'd10:   doy = 9'd245;
            4'd11:   doy = 9'd275;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

@@ src/cdes_days.sv @@
// ----------------------------------------------------------------------------
// cdes_days
// Five-stage day counter: month carry, year range check, days since epoch.
// ----------------------------------------------------------------------------
module cdes_days (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [31:0]        year,
    input  logic signed [31:0]        month,
    output cdes_pkg::day_count_t      result
);

    // stage 1: biased month
    logic [32:0]        m1_reg, m1_next;
    logic signed [31:0] yr1_reg;
    logic signed [33:0] m_sum;

    // stage 2: floor((month - 1) / 12) + 2^28
    logic [62:0]        q_prod;
    logic [28:0]        q2_reg, q2_next;
    logic [3:0]         m2_reg;
    logic signed [31:0] yr2_reg;

    // stage 3: carried year, month index, biased March year
    logic [7:0]         q12;
    logic [3:0]         rem3_reg, rem3_next;
    logic signed [33:0] cy;
    logic signed [33:0] y_full;
    logic [16:0]        y3_reg, y3_next;
    logic               bad3_reg, bad3_next;

    // stage 4: Y/100 and the linear day terms
    logic [34:0]        p100;
    logic [9:0]         d100_reg, d100_next;
    logic signed [26:0] y_s;
    logic signed [26:0] part4_reg, part4_next;
    logic               bad4_reg;

    // stage 5: leap corrections
    logic signed [26:0]   days_full;
    cdes_pkg::day_count_t res_reg, res_next;

    assign m_sum  = 34'(month) - 34'sd1 + cdes_pkg::MONTH_OFS + 34'sd1;
    assign m1_next = m_sum[32:0];

    assign q_prod  = 63'(m1_reg[32:2]) * cdes_pkg::RECIP3;
    assign q2_next = q_prod[61:33];

    assign q12       = {4'b0, q2_reg[3:0]} * 8'd12;
    assign rem3_next = m2_reg - q12[3:0];
    assign cy        = 34'(yr2_reg) + $signed({5'b0, q2_reg}) - cdes_pkg::CARRY_BIAS;
    assign bad3_next = (cy < cdes_pkg::YEAR_LOW) || (cy > cdes_pkg::YEAR_HIGH);
    // Jan and Feb belong to the previous March-based year
    assign y_full    = cy + cdes_pkg::YEAR_BIAS - ((rem3_next < 4'd2) ? 34'sd1 : 34'sd0);
    assign y3_next   = y_full[16:0];

    assign p100       = 35'(y3_reg) * cdes_pkg::RECIP100;
    assign d100_next  = p100[33:24];
    assign y_s        = $signed({10'b0, y3_reg});
    assign part4_next = y_s * 27'sd365 + $signed({12'b0, y3_reg[16:2]})
                      + $signed({18'b0, cdes_pkg::march_doy(rem3_reg)})
                      - cdes_pkg::DAY_BIAS;

    assign days_full         = part4_reg - $signed({17'b0, d100_reg})
                             + $signed({19'b0, d100_reg[9:2]});
    assign res_next.bad_year = bad4_reg;
    assign res_next.days     = days_full[24:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= m1_next;
            yr1_reg   <= year;
            q2_reg    <= q2_next;
            m2_reg    <= m1_reg[3:0];
            yr2_reg   <= yr1_reg;
            rem3_reg  <= rem3_next;
            y3_reg    <= y3_next;
            bad3_reg  <= bad3_next;
            d100_reg  <= d100_next;
            part4_reg <= part4_next;
            bad4_reg  <= bad3_reg;
            res_reg   <= res_next;
        end
    end

    assign result = res_reg;

endmodule

@@ src/civil_datetime_to_epoch_seconds.sv @@
// Throughput: one word per cycle; the seven-stage pipeline advances as a whole
// and holds while the output word waits for m_axis_tready.
// Reset: rst_n (async, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_seconds
// Proleptic Gregorian date and time of day to signed seconds since 1970.
// ----------------------------------------------------------------------------
`include "civil_datetime_to_epoch_seconds_defines.svh"

module civil_datetime_to_epoch_seconds (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // year_in, month_in, day_in, hour_in, minute_in, second_in (32 bits each)
    input  logic [cdes_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // epoch_seconds [40:0], zero fill [47:41]
    output logic [cdes_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // range_fault
    output logic         m_axis_tuser
);

    logic                 en;
    logic [cdes_pkg::PIPE_DEPTH-1:0] valid_reg, valid_next;

    logic signed [31:0]   year_in, month_in, day_in, hour_in, minute_in, second_in;

    // stage 1: time products
    logic signed [48:0]   pday1_reg, pday1_next;
    logic signed [43:0]   phr1_reg, phr1_next;
    logic signed [37:0]   pmin1_reg, pmin1_next;
    logic signed [31:0]   sec1_reg;

    // stage 2..5: time-of-run sum, delayed to meet the day count
    logic signed [50:0]   part2_reg, part2_next;
    logic signed [50:0]   part3_reg, part4_reg, part5_reg;

    cdes_pkg::day_count_t dc;

    // stage 6: day seconds
    logic signed [41:0]   ds6_reg, ds6_next;
    logic signed [50:0]   part6_reg;
    logic                 bad6_reg;

    // stage 7: output word
    logic signed [51:0]   t_sum;
    logic                 bad7_next, bad7_reg;
    logic [cdes_pkg::EPOCH_W-1:0] epoch7_next, epoch7_reg;

    logic                 out_in_span;

    assign year_in   = s_axis_tdata[31:0];
    assign month_in  = s_axis_tdata[63:32];
    assign day_in    = s_axis_tdata[95:64];
    assign hour_in   = s_axis_tdata[127:96];
    assign minute_in = s_axis_tdata[159:128];
    assign second_in = s_axis_tdata[191:160];

    assign en            = !valid_reg[cdes_pkg::PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign valid_next    = {valid_reg[cdes_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    cdes_days u_days (
        .clk    (clk),
        .en     (en),
        .year   (year_in),
        .month  (month_in),
        .result (dc)
    );

    assign pday1_next = 49'(day_in) * 49'sd86400;
    assign phr1_next  = 44'(hour_in) * 44'sd3600;
    assign pmin1_next = 38'(minute_in) * 38'sd60;

    // day counts from 1, so one day comes off
    assign part2_next = 51'(pday1_reg) + 51'(phr1_reg) + 51'(pmin1_reg)
                      + 51'(sec1_reg) - 51'sd86400;

    assign ds6_next = 42'(dc.days) * 42'sd86400;

    assign t_sum       = 52'(ds6_reg) + 52'(part6_reg);
    assign bad7_next   = bad6_reg || (t_sum < cdes_pkg::T_BEGIN) || (t_sum >= cdes_pkg::T_END);
    assign epoch7_next = bad7_next ? '0 : t_sum[cdes_pkg::EPOCH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pday1_reg  <= pday1_next;
            phr1_reg   <= phr1_next;
            pmin1_reg  <= pmin1_next;
            sec1_reg   <= second_in;
            part2_reg  <= part2_next;
            part3_reg  <= part2_reg;
            part4_reg  <= part3_reg;
            part5_reg  <= part4_reg;
            ds6_reg    <= ds6_next;
            part6_reg  <= part5_reg;
            bad6_reg   <= dc.bad_year;
            bad7_reg   <= bad7_next;
            epoch7_reg <= epoch7_next;
        end
    end

    assign m_axis_tvalid = valid_reg[cdes_pkg::PIPE_DEPTH-1];
    assign m_axis_tdata  = {7'b0, epoch7_reg};
    assign m_axis_tuser  = bad7_reg;

    assign out_in_span = ($signed(m_axis_tdata[40:0]) >= cdes_pkg::T_BEGIN)
                      && ($signed(m_axis_tdata[40:0]) < cdes_pkg::T_END);

    `CDES_ASSERT_NOW(a_bad_is_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `CDES_ASSERT_NOW(a_good_in_span, clk, rst_n, m_axis_tvalid && !m_axis_tuser, out_in_span)
    `CDES_ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(valid_reg) && $stable(epoch7_reg))
    `CDES_ASSERT_NEXT(a_accept_enters, clk, rst_n, s_axis_tvalid && s_axis_tready, valid_reg[0])

endmodule
